// ----- src/weighted_random_selector_core_macros.svh -----
// Assertion macros shared by the checker of the weighted random selector.
`ifndef WEIGHTED_RANDOM_SELECTOR_CORE_MACROS_SVH
`define WEIGHTED_RANDOM_SELECTOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define WRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define WRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/wrs_pkg.sv -----
// Types, codes and default sizes of the weighted random selector.
package wrs_pkg;

    localparam int WRS_DEPTH_DEF       = 32;
    localparam int WRS_WEIGHT_BITS_DEF = 16;

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_SEL  = 2'd1;
    localparam logic [1:0] OP_CLR  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;  // unused opcode, dropped without a result

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_SELECTED = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] sound_key;
        logic [15:0] new_weight;
        logic [15:0] random_fraction;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  chosen_index;
        logic [15:0] chosen_key;
        logic [5:0]  entry_count;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic       load;   // latch the accepted beat, rewind the scan
        logic       mul;    // form the select threshold
        logic       scan;   // step the table scan
        logic       pick;   // capture the selected entry
        logic       fix;    // rewrite the matched entry, start the carry pass
        logic       adj;    // step the carry pass over later entries
        logic       ins;    // append an entry
        logic       clr;    // empty the table
        logic       emit;   // load the result register
        logic [2:0] code;   // status of the result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic hit;
        logic drained;
    } t_sts;

endpackage

// ----- src/wrs_ctrl.sv -----
// Sequencing state machine of the weighted random selector.
module wrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_opcode,
    input  wrs_pkg::t_sts i_sts,
    output wrs_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SEEK = 3'd2;
    localparam logic [2:0] S_FIND = 3'd3;
    localparam logic [2:0] S_ADJ  = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_code, n_code;
    wrs_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    case (i_opcode)
                        wrs_pkg::OP_SET: n_state = S_FIND;
                        wrs_pkg::OP_SEL: begin
                            if (i_sts.empty) begin
                                n_code  = wrs_pkg::ST_EMPTY;
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_MUL;
                            end
                        end
                        wrs_pkg::OP_CLR: n_state = S_CLR;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_SEEK;
            end
            S_SEEK: begin
                cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    cmd.pick = 1'b1;
                    n_code   = wrs_pkg::ST_SELECTED;
                    n_state  = S_EMIT;
                end else if (i_sts.drained) begin
                    n_code  = wrs_pkg::ST_EMPTY;
                    n_state = S_EMIT;
                end
            end
            S_FIND: begin
                cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    cmd.fix = 1'b1;
                    n_code  = wrs_pkg::ST_UPDATED;
                    n_state = S_ADJ;
                end else if (i_sts.drained) begin
                    if (i_sts.full) begin
                        n_code = wrs_pkg::ST_FULL;
                    end else begin
                        cmd.ins = 1'b1;
                        n_code  = wrs_pkg::ST_INSERTED;
                    end
                    n_state = S_EMIT;
                end
            end
            S_ADJ: begin
                cmd.adj = 1'b1;
                if (i_sts.drained) begin
                    n_state = S_EMIT;
                end
            end
            S_CLR: begin
                cmd.clr = 1'b1;
                n_code  = wrs_pkg::ST_EMPTY;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                cmd.emit = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        cmd.code = r_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= wrs_pkg::ST_EMPTY;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- src/wrs_datapath.sv -----
// Table memories, scan counters, arithmetic and result register.
module wrs_datapath #(
    parameter int TABLE_DEPTH = wrs_pkg::WRS_DEPTH_DEF,
    parameter int WEIGHT_BITS = wrs_pkg::WRS_WEIGHT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wrs_pkg::t_in  i_item,
    input  wrs_pkg::t_cmd i_cmd,
    output wrs_pkg::t_sts o_sts,
    output logic          o_valid,
    output wrs_pkg::t_out o_result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CUM_W = WEIGHT_BITS + IDX_W;
    localparam int PRD_W = CUM_W + 16;
    localparam logic [CUM_W-1:0] MAX_W = CUM_W'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    logic [15:0]      key_mem [TABLE_DEPTH];
    logic [CUM_W-1:0] cum_mem [TABLE_DEPTH];

    logic [1:0]       r_op;
    logic [15:0]      r_key;
    logic [15:0]      r_frac;
    logic [CUM_W-1:0] r_w;
    logic [CNT_W-1:0] r_used;
    logic [CUM_W-1:0] r_total;
    logic [CUM_W-1:0] r_thr;
    logic [CUM_W-1:0] r_prev;
    logic [CUM_W-1:0] r_own;
    logic [CNT_W-1:0] r_ra;
    logic             r_pv;
    logic [IDX_W-1:0] r_pi;
    logic [15:0]      r_key_q;
    logic [CUM_W-1:0] r_cum_q;
    logic [IDX_W-1:0] r_sel_idx;
    logic [15:0]      r_sel_key;
    logic             r_valid;
    wrs_pkg::t_out    r_result;

    logic [CUM_W-1:0] w_in;
    logic [PRD_W-1:0] prod;
    logic [CUM_W-1:0] own_now;
    logic             match;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic             key_wr;
    logic [IDX_W-1:0] wr_addr;
    logic [CUM_W-1:0] wr_data;
    logic [31:0]      idx_ext;
    logic [31:0]      cnt_ext;

    // clamp the incoming weight to the configured weight range
    assign w_in = (CUM_W'(i_item.new_weight) > MAX_W) ? MAX_W : CUM_W'(i_item.new_weight);

    assign prod    = PRD_W'(r_total) * PRD_W'(r_frac);
    assign own_now = r_cum_q - r_prev;

    assign match = r_pv && ((r_op == wrs_pkg::OP_SEL) ? (r_cum_q >= r_thr)
                                                      : (r_key_q == r_key));

    assign rd_en   = (i_cmd.scan || i_cmd.adj) && (r_ra < r_used);
    assign rd_addr = r_ra[IDX_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        key_wr  = 1'b0;
        wr_addr = r_pi;
        wr_data = r_cum_q - r_own + r_w;
        if (i_cmd.fix) begin
            wr_en   = 1'b1;
            wr_data = r_prev + r_w;
        end else if (i_cmd.ins) begin
            wr_en   = 1'b1;
            key_wr  = 1'b1;
            wr_addr = r_used[IDX_W-1:0];
            wr_data = r_total + r_w;
        end else if (i_cmd.adj && r_pv) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            key_mem[wr_addr] <= r_key;
        end
        if (rd_en) begin
            r_key_q <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            cum_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_cum_q <= cum_mem[rd_addr];
        end
    end

    // control state: fill count, running total, scan pointer, read-valid flag, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_total <= '0;
            r_ra    <= '0;
            r_pv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.load) begin
                r_ra <= '0;
                r_pv <= 1'b0;
            end else if (i_cmd.fix) begin
                r_ra    <= CNT_W'(r_pi) + CNT_W'(1);
                r_pv    <= 1'b0;
                r_total <= r_total - own_now + r_w;
            end else if (i_cmd.scan || i_cmd.adj) begin
                r_pv <= rd_en;
                if (rd_en) begin
                    r_ra <= r_ra + CNT_W'(1);
                end
            end
            if (i_cmd.ins) begin
                r_used  <= r_used + CNT_W'(1);
                r_total <= r_total + r_w;
            end
            if (i_cmd.clr) begin
                r_used  <= '0;
                r_total <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_item.opcode;
            r_key  <= i_item.sound_key;
            r_frac <= i_item.random_fraction;
            r_w    <= w_in;
            r_prev <= '0;
        end else if (i_cmd.scan && r_pv && !match) begin
            r_prev <= r_cum_q;
        end
        if (i_cmd.mul) begin
            r_thr <= prod[PRD_W-1:16];
        end
        if (rd_en && !i_cmd.fix) begin
            r_pi <= rd_addr;
        end
        if (i_cmd.fix) begin
            r_own <= own_now;
        end
        if (i_cmd.pick || i_cmd.fix) begin
            r_sel_idx <= r_pi;
            r_sel_key <= r_key_q;
        end else if (i_cmd.ins) begin
            r_sel_idx <= r_used[IDX_W-1:0];
            r_sel_key <= r_key;
        end
    end

    assign idx_ext = 32'(r_sel_idx);
    assign cnt_ext = 32'(r_used);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result.status      <= i_cmd.code;
            r_result.entry_count <= cnt_ext[5:0];
            if (i_cmd.code == wrs_pkg::ST_EMPTY || i_cmd.code == wrs_pkg::ST_FULL) begin
                r_result.chosen_index <= '0;
                r_result.chosen_key   <= '0;
            end else begin
                r_result.chosen_index <= idx_ext[4:0];
                r_result.chosen_key   <= r_sel_key;
            end
        end
    end

    assign o_sts.empty   = (r_used == '0);
    assign o_sts.full    = (r_used == DEPTH_CNT);
    assign o_sts.hit     = match;
    assign o_sts.drained = !r_pv && (r_ra >= r_used);
    assign o_valid       = r_valid;
    assign o_result      = r_result;

endmodule

// ----- src/weighted_random_selector_core.sv -----
// Top level of the weighted random selector: controller plus table datapath.
// Clear runs its clear state; select forms the threshold and scans to entry k, or skips
// both on an empty table; a set scans to its key or the fill count, an update then runs
// the carry pass. One entry is scanned per cycle through the registered read port.
// Throughput: one beat at a time; busy drops in the result cycle, when a new beat can be
// taken. Results cannot be stalled. Synchronous active-low reset empties the table.
module weighted_random_selector_core #(
    parameter int TABLE_DEPTH = wrs_pkg::WRS_DEPTH_DEF,
    parameter int WEIGHT_BITS = wrs_pkg::WRS_WEIGHT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  wrs_pkg::t_in  i_item,
    output logic          o_valid,
    output wrs_pkg::t_out o_result
);

    // command and status between the controller and the datapath
    wrs_pkg::t_cmd cmd;
    wrs_pkg::t_sts sts;

    // controller: decodes the accepted beat and steps scan, carry and emit
    wrs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_item.opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // datapath: key and cumulative-weight memories, running total, threshold
    wrs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// ----- src/wrs_checker.sv -----
// Port-level checker of the weighted random selector, bound to the top level.
`include "weighted_random_selector_core_macros.svh"

module wrs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input wrs_pkg::t_in  i_item,
    input logic          o_valid,
    input wrs_pkg::t_out o_result
);

    // an accepted beat with a real opcode holds the block busy
    `WRS_ASSERT_NXT(a_busy_after_accept, start && !busy && i_item.opcode != wrs_pkg::OP_NONE, busy, "no busy after accepted beat")
    // one result per beat: strobes never run back to back
    `WRS_ASSERT_NXT(a_single_strobe, o_valid, !o_valid, "result strobe longer than one cycle")
    // a result shows only once the work is done
    `WRS_ASSERT_IMP(a_idle_on_result, o_valid, !busy, "result shown while busy")
    // empty and full results carry no entry
    `WRS_ASSERT_IMP(a_no_entry, o_valid && (o_result.status == wrs_pkg::ST_EMPTY || o_result.status == wrs_pkg::ST_FULL), o_result.chosen_index == 5'd0 && o_result.chosen_key == 16'd0, "entry fields set on empty or full")
    // a result's status is a defined code
    `WRS_ASSERT_IMP(a_status_code, o_valid, o_result.status == wrs_pkg::ST_UPDATED || o_result.status == wrs_pkg::ST_INSERTED || o_result.status == wrs_pkg::ST_SELECTED || o_result.status == wrs_pkg::ST_EMPTY || o_result.status == wrs_pkg::ST_FULL, "undefined status code")

endmodule

bind weighted_random_selector_core wrs_checker u_wrs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);

// ----- tb/tb_weighted_random_selector_core.sv -----
// Self-checking testbench for the weighted random selector core.
`timescale 1ns / 1ps

module tb_weighted_random_selector_core;

    localparam int DEPTH      = wrs_pkg::WRS_DEPTH_DEF;
    localparam int WBITS      = wrs_pkg::WRS_WEIGHT_BITS_DEF;
    localparam int SUM_BITS   = 21;
    localparam int RAND_BEATS = 800;
    localparam int IDLE_LIMIT = 2000;   // cycles with no beat moving either way
    localparam int TAIL_WAIT  = 60;     // longer than the slowest scan of a full table
    localparam int MAX_SHOWN  = 10;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic          busy;
    wrs_pkg::t_in  i_item  = '0;
    logic          o_valid;
    wrs_pkg::t_out o_result;

    weighted_random_selector_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // Predicted table contents: keys, running sums and fill count.
    logic [15:0]         tbl_key [DEPTH];
    logic [SUM_BITS-1:0] tbl_sum [DEPTH];
    int unsigned         tbl_fill = 0;

    wrs_pkg::t_in  pending_beats[$];     // command beats waiting for the driver
    wrs_pkg::t_out awaited_results[$];   // predicted result beats, oldest first

    int unsigned total_beats = 0;
    int unsigned beats_sent  = 0;
    int unsigned err_cnt     = 0;
    int unsigned idle_cycles = 0;

    // Append a command beat to the driver's queue.
    function automatic void queue_beat(input wrs_pkg::t_in b);
        pending_beats = {pending_beats, b};
    endfunction

    // Spin the wheel model for one command beat; return 1 when a result follows.
    function automatic bit spin_wheel(input wrs_pkg::t_in beat, output wrs_pkg::t_out res);
        logic [SUM_BITS-1:0] w;
        logic [SUM_BITS-1:0] prev_sum;
        logic [SUM_BITS-1:0] own_w;
        longint unsigned     thr;
        bit                  found;
        int unsigned         hit_idx;
        res      = '0;
        found    = 1'b0;
        hit_idx  = 0;
        w        = SUM_BITS'(beat.new_weight);
        if (WBITS < 16 && beat.new_weight > ((1 << WBITS) - 1))
            w = SUM_BITS'((1 << WBITS) - 1);
        case (beat.opcode)
            wrs_pkg::OP_SET: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (!found && i < tbl_fill && tbl_key[i] == beat.sound_key) begin
                        found   = 1'b1;
                        hit_idx = i;
                    end
                end
                if (found) begin
                    // Replace the entry's own weight, carry the difference forward.
                    prev_sum = (hit_idx > 0) ? tbl_sum[hit_idx-1] : '0;
                    own_w    = tbl_sum[hit_idx] - prev_sum;
                    tbl_sum[hit_idx] = prev_sum + w;
                    for (int j = 0; j < DEPTH; j++)
                        if (j > hit_idx && j < tbl_fill)
                            tbl_sum[j] = tbl_sum[j] - own_w + w;
                    res.status       = wrs_pkg::ST_UPDATED;
                    res.chosen_index = 5'(hit_idx);
                    res.chosen_key   = beat.sound_key;
                end else if (tbl_fill >= DEPTH) begin
                    res.status = wrs_pkg::ST_FULL;
                end else begin
                    prev_sum = (tbl_fill > 0) ? tbl_sum[tbl_fill-1] : '0;
                    tbl_key[tbl_fill] = beat.sound_key;
                    tbl_sum[tbl_fill] = prev_sum + w;
                    res.status       = wrs_pkg::ST_INSERTED;
                    res.chosen_index = 5'(tbl_fill);
                    res.chosen_key   = beat.sound_key;
                    tbl_fill++;
                end
            end
            wrs_pkg::OP_SEL: begin
                if (tbl_fill == 0) begin
                    res.status = wrs_pkg::ST_EMPTY;
                end else begin
                    thr = (longint'(tbl_sum[tbl_fill-1]) *
                           longint'(beat.random_fraction)) >> 16;
                    hit_idx = tbl_fill - 1;
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (i < tbl_fill && longint'(tbl_sum[i]) >= thr)
                            hit_idx = i;
                    res.status       = wrs_pkg::ST_SELECTED;
                    res.chosen_index = 5'(hit_idx);
                    res.chosen_key   = tbl_key[hit_idx];
                end
            end
            wrs_pkg::OP_CLR: begin
                tbl_fill   = 0;
                res.status = wrs_pkg::ST_EMPTY;
            end
            default: return 1'b0;
        endcase
        res.entry_count = 6'(tbl_fill);
        return 1'b1;
    endfunction

    function automatic wrs_pkg::t_in mk_beat(logic [1:0] op, logic [15:0] key,
                                             logic [15:0] w, logic [15:0] frac);
        wrs_pkg::t_in b;
        b.opcode          = op;
        b.sound_key       = key;
        b.new_weight      = w;
        b.random_fraction = frac;
        return b;
    endfunction

    // Lean on the extremes now and then, otherwise draw the full range.
    function automatic logic [15:0] pick_value();
        int unsigned r;
        r = $urandom_range(7);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Driver: launch one beat at a time, hold it until the core takes it.
    // Each time it may launch, the sender holds back with a chance of 24 in 100 for the first
    // third of the run, 63 in 100 for the second third, and never in the last third.
    always @(posedge i_clk) begin
        wrs_pkg::t_out res;
        bit            taken;
        int unsigned   idle_pct;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && (busy === 1'b0);
            if (taken && spin_wheel(i_item, res))
                awaited_results = {awaited_results, res};
            if (!start || taken) begin
                if (beats_sent < total_beats / 3)
                    idle_pct = 24;
                else if (beats_sent < (2 * total_beats) / 3)
                    idle_pct = 63;
                else
                    idle_pct = 0;
                if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    start  <= 1'b1;
                    i_item <= pending_beats.pop_front();
                    beats_sent++;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: take each result beat and match it against the oldest prediction.
    always @(posedge i_clk) begin
        wrs_pkg::t_out want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (awaited_results.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_SHOWN)
                    $display("unexpected result beat: status %0d index %0d key %h count %0d",
                             o_result.status, o_result.chosen_index,
                             o_result.chosen_key, o_result.entry_count);
            end else begin
                want = awaited_results.pop_front();
                if (o_result.status !== want.status ||
                    o_result.chosen_index !== want.chosen_index ||
                    o_result.chosen_key !== want.chosen_key ||
                    o_result.entry_count !== want.entry_count) begin
                    err_cnt++;
                    if (err_cnt <= MAX_SHOWN)
                        $display({"mismatch: exp status %0d index %0d key %h count %0d,",
                                  " got %0d %0d %h %0d"},
                                 want.status, want.chosen_index, want.chosen_key,
                                 want.entry_count, o_result.status, o_result.chosen_index,
                                 o_result.chosen_key, o_result.entry_count);
                end
            end
        end
    end

    // Watchdog: drop the run when neither side moves a beat for too long.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0 && i_rst_n) || o_valid === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int unsigned    n_rand;
        int unsigned    kind;
        int unsigned    seq_len;
        int unsigned    pool_size;
        logic [15:0]    key_pool [48];
        logic [1:0]     op;
        int unsigned    r;

        // Directed part: empty table, zero total, extremes, carry through
        // later sums, the unused opcode and a select right after a clear.
        queue_beat(mk_beat(wrs_pkg::OP_SEL, 16'h0000, 16'h0000, 16'h8000));
        queue_beat(mk_beat(wrs_pkg::OP_CLR, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_beat(mk_beat(wrs_pkg::OP_SET, 16'h0000, 16'h0000, 16'h0000));
        queue_beat(mk_beat(wrs_pkg::OP_SEL, 16'h0000, 16'h0000, 16'hFFFF));
        queue_beat(mk_beat(wrs_pkg::OP_SEL, 16'h0000, 16'h0000, 16'h0000));
        queue_beat(mk_beat(wrs_pkg::OP_SET, 16'hFFFF, 16'hFFFF, 16'h0000));
        queue_beat(mk_beat(wrs_pkg::OP_SET, 16'h0000, 16'hFFFF, 16'h0000));
        queue_beat(mk_beat(wrs_pkg::OP_SEL, 16'h0000, 16'h0000, 16'hFFFF));
        queue_beat(mk_beat(wrs_pkg::OP_SEL, 16'h0000, 16'h0000, 16'h0000));
        queue_beat(mk_beat(wrs_pkg::OP_SET, 16'h1234, 16'h0001, 16'h0000));
        queue_beat(mk_beat(wrs_pkg::OP_SEL, 16'h0000, 16'h0000, 16'h8000));
        queue_beat(mk_beat(wrs_pkg::OP_SET, 16'hFFFF, 16'h0000, 16'h0000));
        queue_beat(mk_beat(wrs_pkg::OP_SEL, 16'h0000, 16'h0000, 16'hFFFF));
        queue_beat(mk_beat(wrs_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_beat(mk_beat(wrs_pkg::OP_SET, 16'h0000, 16'h0000, 16'h0000));
        queue_beat(mk_beat(wrs_pkg::OP_SEL, 16'h0000, 16'h0000, 16'h0001));
        queue_beat(mk_beat(wrs_pkg::OP_CLR, 16'h0000, 16'h0000, 16'h0000));
        queue_beat(mk_beat(wrs_pkg::OP_SEL, 16'h0000, 16'h0000, 16'hFFFF));
        queue_beat(mk_beat(wrs_pkg::OP_SET, 16'hFFFF, 16'h5555, 16'h5555));
        queue_beat(mk_beat(wrs_pkg::OP_SET, 16'hAAAA, 16'hAAAA, 16'hAAAA));
        queue_beat(mk_beat(wrs_pkg::OP_SEL, 16'h5555, 16'h5555, 16'hAAAA));
        queue_beat(mk_beat(wrs_pkg::OP_CLR, 16'h0000, 16'h0000, 16'h0000));

        // Random part, built from sequences: fill runs that drive the table
        // towards full and at times beyond, mixed runs over a small key pool so updates
        // hit often, and short stretches of raw noise.
        n_rand = 0;
        while (n_rand < RAND_BEATS) begin
            kind = $urandom_range(9);
            if (kind < 2) begin
                queue_beat(mk_beat(wrs_pkg::OP_CLR, 16'($urandom), 16'($urandom),
                                   16'($urandom)));
                n_rand++;
                seq_len = $urandom_range(40, 33);
                for (int i = 0; i < seq_len; i++) begin
                    if ($urandom_range(5) == 0)
                        op = wrs_pkg::OP_SEL;
                    else
                        op = wrs_pkg::OP_SET;
                    queue_beat(mk_beat(op, 16'($urandom), pick_value(), pick_value()));
                    n_rand++;
                end
            end else if (kind < 9) begin
                pool_size = $urandom_range(16, 1);
                for (int i = 0; i < pool_size; i++)
                    key_pool[i] = pick_value() ^ 16'($urandom_range(1) ? $urandom : 0);
                seq_len = $urandom_range(40, 10);
                for (int i = 0; i < seq_len; i++) begin
                    r = $urandom_range(99);
                    if (r < 55)
                        op = wrs_pkg::OP_SET;
                    else if (r < 95)
                        op = wrs_pkg::OP_SEL;
                    else
                        op = wrs_pkg::OP_CLR;
                    queue_beat(mk_beat(op, key_pool[$urandom_range(pool_size-1)],
                                       pick_value(), pick_value()));
                    n_rand++;
                end
            end else begin
                seq_len = $urandom_range(6, 2);
                for (int i = 0; i < seq_len; i++) begin
                    op = 2'($urandom);
                    queue_beat(mk_beat(op, 16'($urandom), 16'($urandom), 16'($urandom)));
                    if (op != wrs_pkg::OP_NONE)
                        n_rand++;
                end
            end
        end
        total_beats = pending_beats.size();

        // Hold reset at the start, then release it for good.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the queue to drain and the core to settle, then a tail.
        @(posedge i_clk);
        while (!(pending_beats.size() == 0 && !start && awaited_results.size() == 0 &&
                 busy === 1'b0))
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (err_cnt == 0 && awaited_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
